>>> rtl/core/wsfhp_pkg.sv
// Package for the frame header parser: header snapshot type, status codes,
// length indicator codes and the header size function. No dependencies.
`timescale 1ns / 1ps

package wsfhp_pkg;

  typedef struct packed {
    logic [7:0]  first;
    logic [7:0]  second;
    logic [63:0] ext_len;
    logic [31:0] key;
  } hdr_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_RSV_SET    = 3'd3;
  localparam logic [2:0] ST_BAD_OPCODE = 3'd4;
  localparam logic [2:0] ST_UNMASKED   = 3'd5;

  localparam logic [6:0] IND_LEN64 = 7'd127;
  localparam logic [6:0] IND_LEN16 = 7'd126;

  localparam logic [3:0] HDR_SHORT = 4'd6;
  localparam logic [3:0] HDR_LEN16 = 4'd8;
  localparam logic [3:0] HDR_LEN64 = 4'd14;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  localparam logic [3:0] OPC_LAST_DATA = 4'h2;
  localparam logic [3:0] OPC_FIRST_CTL = 4'h8;
  localparam logic [3:0] OPC_LAST_CTL  = 4'hA;

  localparam int QUEUE_DEPTH = 2;

  function automatic logic [3:0] hdr_size(input logic [7:0] second);
    logic [3:0] sz;
    if (second[6:0] == IND_LEN64) begin
      sz = HDR_LEN64;
    end else if (second[6:0] == IND_LEN16) begin
      sz = HDR_LEN16;
    end else begin
      sz = HDR_SHORT;
    end
    return sz;
  endfunction

endpackage

>>> rtl/core/wsfhp_front.sv
// Front part: takes buffer bytes, counts them and captures header fields.
// Pushes a header snapshot on the last byte. Uses wsfhp_pkg.
`timescale 1ns / 1ps

module wsfhp_front import wsfhp_pkg::*; #(
  parameter int MAX_BUFFER_BYTES = 65536,
  parameter int CW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          q_full,
  output logic          push,
  output logic [CW-1:0] push_count,
  output hdr_t          push_hdr
);

  logic [CW-1:0] count, count_next;
  hdr_t          hdr, hdr_next;
  logic [3:0]    h;
  logic          accept;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign push     = accept & last_byte;

  always_comb begin
    hdr_next   = hdr;
    count_next = count;
    h          = hdr_size(hdr.second);
    if (count == '0) begin
      hdr_next.first = data_byte;
    end else if (count == CW'(1)) begin
      hdr_next.second = data_byte;
    end else if (32'(count) < 32'(h)) begin
      if (32'(count) < 32'(h - KEY_BYTES)) begin
        hdr_next.ext_len = {hdr.ext_len[55:0], data_byte};
      end else begin
        hdr_next.key = {hdr.key[23:0], data_byte};
      end
    end
    if (count != CW'(MAX_BUFFER_BYTES)) begin
      count_next = count + CW'(1);
    end
  end

  assign push_count = count_next;
  assign push_hdr   = hdr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      hdr   <= '0;
    end else if (accept) begin
      if (last_byte) begin
        count <= '0;
        hdr   <= '0;
      end else begin
        count <= count_next;
        hdr   <= hdr_next;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_BUFFER_BYTES)
    else $error("byte count above bound");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> (count == '0) && (hdr == '0))
    else $error("state not cleared after last byte");

endmodule

>>> rtl/core/wsfhp_queue.sv
// Short queue between front and back parts.
// Holds header snapshots; depth from wsfhp_pkg.
`timescale 1ns / 1ps

module wsfhp_queue import wsfhp_pkg::*; #(
  parameter int W = 129
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         q_valid,
  input  logic         pop,
  output logic [W-1:0] q_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [FW-1:0] fill;

  assign full    = (fill == FW'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (!push && pop) begin
        fill <= fill - FW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

>>> rtl/core/wsfhp_back.sv
// Back part: runs the header checks on a queued snapshot and holds the
// result in the output register. Uses wsfhp_pkg.
`timescale 1ns / 1ps

module wsfhp_back import wsfhp_pkg::*; #(
  parameter int CW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  logic [CW-1:0] q_count,
  input  hdr_t          q_hdr,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic          fin_flag,
  output logic [3:0]    frame_opcode,
  output logic [63:0]   payload_length,
  output logic [31:0]   mask_key,
  output logic [3:0]    header_bytes
);

  logic [3:0]  h, opc;
  logic [63:0] plen, room;
  logic        too_short, bad_opc;
  logic [2:0]  st;

  assign pop = q_valid & (~out_valid | out_ready);

  always_comb begin
    h         = hdr_size(q_hdr.second);
    opc       = q_hdr.first[3:0];
    plen      = (q_hdr.second[6:0] == IND_LEN64 || q_hdr.second[6:0] == IND_LEN16) ?
                q_hdr.ext_len : 64'(q_hdr.second[6:0]);
    too_short = (32'(q_count) < 32'(HDR_SHORT)) || (32'(q_count) < 32'(h));
    room      = 64'(32'(q_count) - 32'(h));
    bad_opc   = ((opc > OPC_LAST_DATA) && (opc < OPC_FIRST_CTL)) || (opc > OPC_LAST_CTL);
    if (too_short) begin
      st = ST_TOO_SHORT;
    end else if (room < plen) begin
      st = ST_INCOMPLETE;
    end else if (q_hdr.first[6:4] != 3'b000) begin
      st = ST_RSV_SET;
    end else if (bad_opc) begin
      st = ST_BAD_OPCODE;
    end else if (!q_hdr.second[7]) begin
      st = ST_UNMASKED;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status <= st;
      if (too_short) begin
        fin_flag       <= 1'b0;
        frame_opcode   <= '0;
        payload_length <= '0;
        mask_key       <= '0;
        header_bytes   <= '0;
      end else begin
        fin_flag       <= q_hdr.first[7];
        frame_opcode   <= opc;
        payload_length <= plen;
        mask_key       <= q_hdr.key;
        header_bytes   <= h;
      end
    end
  end

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_TOO_SHORT) |->
      (payload_length == '0 && header_bytes == '0 && mask_key == '0))
    else $error("too-short result with nonzero fields");

  a_hdr_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_TOO_SHORT) |->
      (header_bytes == HDR_SHORT || header_bytes == HDR_LEN16 ||
       header_bytes == HDR_LEN64))
    else $error("bad header size in result");

endmodule

>>> rtl/core/websocket_frame_header_parser_unit.sv
// Frame header parser top level: front capture, snapshot queue, back checks.
// Result path: a last byte's snapshot goes through the queue into the output register.
// Throughput: one byte per cycle; in_ready drops only while the 2-entry queue is full.
// Results: one per buffer, issued at most one per cycle by the back part.
// Reset: synchronous; clears byte count, captured header, queue and output valid.
`timescale 1ns / 1ps

module websocket_frame_header_parser_unit import wsfhp_pkg::*; #(
  parameter int MAX_BUFFER_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        fin_flag,
  output logic [3:0]  frame_opcode,
  output logic [63:0] payload_length,
  output logic [31:0] mask_key,
  output logic [3:0]  header_bytes
);

  localparam int CW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int HW = $bits(hdr_t);
  localparam int QW = CW + HW;

  logic          push, q_full, q_valid, pop;
  logic [CW-1:0] push_count, q_count;
  hdr_t          push_hdr, q_hdr;
  logic [QW-1:0] q_data;

  wsfhp_front #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .q_full(q_full),
    .push(push),
    .push_count(push_count),
    .push_hdr(push_hdr)
  );

  wsfhp_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data({push_count, push_hdr}),
    .full(q_full),
    .q_valid(q_valid),
    .pop(pop),
    .q_data(q_data)
  );

  assign q_count = q_data[QW-1 -: CW];
  assign q_hdr   = q_data[HW-1:0];

  wsfhp_back #(
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_count(q_count),
    .q_hdr(q_hdr),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .fin_flag(fin_flag),
    .frame_opcode(frame_opcode),
    .payload_length(payload_length),
    .mask_key(mask_key),
    .header_bytes(header_bytes)
  );

endmodule

>>> bench/tb_websocket_frame_header_parser_unit.sv
`timescale 1ns / 1ps
// Testbench for websocket_frame_header_parser_unit: feeds buffers byte by byte,
// predicts or looks up each buffer's header check result and compares it field by field.
// Depends on wsfhp_pkg and the parser RTL.

module tb_websocket_frame_header_parser_unit;
  import wsfhp_pkg::*;

  localparam int MAX_BUF        = 65536;
  localparam int RANDOM_BYTES   = 700;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int HOLD_AT_RESULT = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int N_DIR          = 9;

  typedef struct packed {
    logic [2:0]  st;
    logic        fin;
    logic [3:0]  opc;
    logic [63:0] plen;
    logic [31:0] key;
    logic [3:0]  hdr;
  } frame_result_t;

  typedef struct packed {
    logic [127:0]  bytes;
    logic [4:0]    nbytes;
    logic          typed;
    frame_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic [63:0] payload_length;
  logic [31:0] mask_key;
  logic [3:0]  header_bytes;

  // predictor state
  int unsigned rx_count = 0;
  logic [7:0]  hdr0 = '0;
  logic [7:0]  hdr1 = '0;
  logic [63:0] ext_len = '0;
  logic [31:0] key_reg = '0;

  frame_result_t frame_results_due[$];
  logic [7:0]    pending_bytes[$];
  dir_row_t      dir_rows[N_DIR];
  bit            use_typed = 1'b0;
  frame_result_t typed_want = '0;
  int            mismatches = 0;
  int            bytes_sent = 0;
  int            results_seen = 0;

  websocket_frame_header_parser_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .fin_flag       (fin_flag),
    .frame_opcode   (frame_opcode),
    .payload_length (payload_length),
    .mask_key       (mask_key),
    .header_bytes   (header_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [3:0] header_len(input logic [7:0] second);
    case (second[6:0])
      IND_LEN64: header_len = HDR_LEN64;
      IND_LEN16: header_len = HDR_LEN16;
      default:   header_len = HDR_SHORT;
    endcase
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic lst,
                                    output frame_result_t res);
    logic [3:0]  h;
    logic [3:0]  opc;
    logic [63:0] plen;
    int unsigned len;
    res = '0;
    if (rx_count == 0) begin
      hdr0 = b;
    end else if (rx_count == 1) begin
      hdr1 = b;
    end else begin
      h = header_len(hdr1);
      if (rx_count < h) begin
        if (rx_count < h - KEY_BYTES) begin
          ext_len = {ext_len[55:0], b};
        end else begin
          key_reg = {key_reg[23:0], b};
        end
      end
    end
    if (rx_count < MAX_BUF) rx_count++;
    if (!lst) return 1'b0;

    len = rx_count;
    h = header_len(hdr1);
    plen = (hdr1[6:0] == IND_LEN64 || hdr1[6:0] == IND_LEN16) ? ext_len : 64'(hdr1[6:0]);
    if (len < HDR_SHORT || len < h) begin
      res.st = ST_TOO_SHORT;
    end else begin
      opc = hdr0[3:0];
      if (64'(len - h) < plen) begin
        res.st = ST_INCOMPLETE;
      end else if (hdr0[6:4] != 3'b000) begin
        res.st = ST_RSV_SET;
      end else if ((opc > OPC_LAST_DATA && opc < OPC_FIRST_CTL) || opc > OPC_LAST_CTL) begin
        res.st = ST_BAD_OPCODE;
      end else if (!hdr1[7]) begin
        res.st = ST_UNMASKED;
      end else begin
        res.st = ST_OK;
      end
      res.fin  = hdr0[7];
      res.opc  = opc;
      res.plen = plen;
      res.key  = key_reg;
      res.hdr  = h;
    end
    rx_count = 0;
    hdr0 = '0;
    hdr1 = '0;
    ext_len = '0;
    key_reg = '0;
    return 1'b1;
  endfunction

  task automatic flush_buffer(input bit no_gap);
    frame_result_t r;
    logic [7:0]    b;
    logic          lst;
    int            gap;
    while (pending_bytes.size() > 0) begin
      b = pending_bytes.pop_front();
      lst = (pending_bytes.size() == 0);
      gap = no_gap ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= b;
      last_byte <= lst;
      do @(posedge clk); while (!in_ready);
      bytes_sent++;
      if (parse_byte(b, lst, r)) frame_results_due.push_back(use_typed ? typed_want : r);
    end
  endtask

  // mostly well-formed frames with random content, some noise, some cut short
  task automatic build_random_buffer();
    logic [7:0]  b0;
    logic [3:0]  opc;
    logic [63:0] plen;
    logic        msk;
    int          k;
    int          n;
    int          pay;
    if ($urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, 20);
      repeat (n) pending_bytes.push_back(8'($urandom));
    end else begin
      k = $urandom_range(0, 5);
      opc = (k < 3) ? 4'(k) : 4'(OPC_FIRST_CTL + k - 3);
      b0 = {1'($urandom), 3'b000, opc};
      if ($urandom_range(0, 4) == 0) b0 = 8'($urandom);
      msk = ($urandom_range(0, 7) != 0);
      pending_bytes.push_back(b0);
      case ($urandom_range(0, 2))
        0: begin
          if ($urandom_range(0, 3) == 0) plen = 64'($urandom_range(0, 125));
          else plen = 64'($urandom_range(0, 12));
          pending_bytes.push_back({msk, plen[6:0]});
        end
        1: begin
          if ($urandom_range(0, 3) == 0) plen = 64'($urandom_range(0, 65535));
          else plen = 64'($urandom_range(0, 12));
          pending_bytes.push_back({msk, IND_LEN16});
          pending_bytes.push_back(plen[15:8]);
          pending_bytes.push_back(plen[7:0]);
        end
        default: begin
          plen = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 12));
          pending_bytes.push_back({msk, IND_LEN64});
          for (int i = 7; i >= 0; i--) pending_bytes.push_back(plen[8*i +: 8]);
        end
      endcase
      repeat (4) pending_bytes.push_back(8'($urandom));
      pay = (plen > 40) ? $urandom_range(0, 40) : int'(plen);
      k = $urandom_range(0, 99);
      if (k < 10) begin
        pay += $urandom_range(1, 4);
      end else if (k < 20) begin
        pay = (pay > 0) ? pay - 1 : 0;
      end
      repeat (pay) pending_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 99) < 8) begin
        n = $urandom_range(1, pending_bytes.size() - 1);
        while (pending_bytes.size() > n) void'(pending_bytes.pop_back());
      end
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    frame_result_t got;
    got = {status, fin_flag, frame_opcode, payload_length, mask_key, header_bytes};
    if (frame_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: st=%0d fin=%0d opc=%h len=%h key=%h hdr=%0d",
                 got.st, got.fin, got.opc, got.plen, got.key, got.hdr);
    end else begin
      want = frame_results_due.pop_front();
      if (got.st !== want.st || got.fin !== want.fin || got.opc !== want.opc ||
          got.plen !== want.plen || got.key !== want.key || got.hdr !== want.hdr) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp st=%0d fin=%0d opc=%h len=%h key=%h hdr=%0d",
                   want.st, want.fin, want.opc, want.plen, want.key, want.hdr);
          $display("          got st=%0d fin=%0d opc=%h len=%h key=%h hdr=%0d",
                   got.st, got.fin, got.opc, got.plen, got.key, got.hdr);
        end
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        check_result();
        results_seen++;
        if (results_seen == HOLD_AT_RESULT) begin
          gap = HOLD_CYCLES;
        end else begin
          gap = (results_seen % 8 < 2) ? 0 : $urandom_range(0, 4);
        end
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int nbuf;
    int start;

    dir_rows[0] = '{{8'h00, 120'h0}, 5'd1, 1'b1,
                    '{ST_TOO_SHORT, 1'b0, 4'h0, 64'h0, 32'h0, 4'h0}};
    dir_rows[1] = '{{40'h81_80_11_22_33, 88'h0}, 5'd5, 1'b1,
                    '{ST_TOO_SHORT, 1'b0, 4'h0, 64'h0, 32'h0, 4'h0}};
    dir_rows[2] = '{{48'h81_80_A1_B2_C3_D4, 80'h0}, 5'd6, 1'b1,
                    '{ST_OK, 1'b1, 4'h1, 64'h0, 32'hA1B2_C3D4, HDR_SHORT}};
    dir_rows[3] = '{{{14{8'hFF}}, 16'h0}, 5'd14, 1'b1,
                    '{ST_INCOMPLETE, 1'b1, 4'hF, {64{1'b1}}, 32'hFFFF_FFFF, HDR_LEN64}};
    dir_rows[4] = '{{64'h8A_7E_00_00_00_00_00_00, 64'h0}, 5'd8, 1'b1,
                    '{ST_UNMASKED, 1'b1, 4'hA, 64'h0, 32'h0, HDR_LEN16}};
    dir_rows[5] = '{{88'h71_85_01_02_03_04_AA_BB_CC_DD_EE, 40'h0}, 5'd11, 1'b1,
                    '{ST_RSV_SET, 1'b0, 4'h1, 64'd5, 32'h0102_0304, HDR_SHORT}};
    dir_rows[6] = '{{48'h03_80_11_22_33_44, 80'h0}, 5'd6, 1'b0, '0};
    dir_rows[7] = '{{80'h80_FE_00_02_55_66_77_88_99_AA, 48'h0}, 5'd10, 1'b0, '0};
    // length indicator asks for a longer header than the buffer holds
    dir_rows[8] = '{{56'h81_FE_00_01_AA_BB_CC, 72'h0}, 5'd7, 1'b1,
                    '{ST_TOO_SHORT, 1'b0, 4'h0, 64'h0, 32'h0, 4'h0}};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIR; r++) begin
      for (int i = 0; i < dir_rows[r].nbytes; i++)
        pending_bytes.push_back(dir_rows[r].bytes[127 - 8*i -: 8]);
      use_typed  = dir_rows[r].typed;
      typed_want = dir_rows[r].want;
      flush_buffer(1'b0);
    end
    use_typed = 1'b0;

    nbuf = 0;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      build_random_buffer();
      flush_buffer(nbuf % 10 < 2);
      nbuf++;
    end

    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
